[rtl/core/mtcu_pkg.sv]
// Shared types and constants of the machine trap and CSR unit.
// No dependencies; used by mtcu_calc, the top level and the testbench.
`default_nettype none
package mtcu_pkg;

  // Item action codes.
  localparam logic [3:0] ActCsrWrite = 4'd0;
  localparam logic [3:0] ActCsrSet   = 4'd1;
  localparam logic [3:0] ActCsrClear = 4'd2;
  localparam logic [3:0] ActEcall    = 4'd3;
  localparam logic [3:0] ActEbreak   = 4'd4;
  localparam logic [3:0] ActMret     = 4'd5;
  localparam logic [3:0] ActSret     = 4'd6;
  localparam logic [3:0] ActExcept   = 4'd7;
  localparam logic [3:0] ActIrqCheck = 4'd8;

  // CSR addresses.
  localparam logic [11:0] AddrMstatus   = 12'h300;
  localparam logic [11:0] AddrMisa      = 12'h301;
  localparam logic [11:0] AddrMedeleg   = 12'h302;
  localparam logic [11:0] AddrMideleg   = 12'h303;
  localparam logic [11:0] AddrMie       = 12'h304;
  localparam logic [11:0] AddrMtvec     = 12'h305;
  localparam logic [11:0] AddrMepc      = 12'h341;
  localparam logic [11:0] AddrMcause    = 12'h342;
  localparam logic [11:0] AddrMtval     = 12'h343;
  localparam logic [11:0] AddrMip       = 12'h344;
  localparam logic [11:0] AddrStvec     = 12'h105;
  localparam logic [11:0] AddrSepc      = 12'h141;
  localparam logic [11:0] AddrScause    = 12'h142;
  localparam logic [11:0] AddrStval     = 12'h143;
  localparam logic [11:0] AddrMvendorid = 12'hF11;
  localparam logic [11:0] AddrMarchid   = 12'hF12;
  localparam logic [11:0] AddrMimpid    = 12'hF13;
  localparam logic [11:0] AddrMhartid   = 12'hF14;

  localparam logic [63:0] MisaValue   = (64'd2 << 62) | (64'd1 << 8);
  localparam logic [63:0] MstatusMask = (64'd1 << 63) | (64'd3 << 13) | (64'd3 << 11) |
                                        (64'd1 << 8) | (64'd1 << 7) | (64'd1 << 5) |
                                        (64'd1 << 3) | (64'd1 << 1);

  // Privilege levels.
  localparam logic [1:0] PrivUser    = 2'd0;
  localparam logic [1:0] PrivSuper   = 2'd1;
  localparam logic [1:0] PrivMachine = 2'd3;

  // Snapshot slots read from the store before a trap or return.
  localparam int unsigned NumSnap = 9;
  localparam logic [3:0] SnapMstatus = 4'd0;
  localparam logic [3:0] SnapMip     = 4'd1;
  localparam logic [3:0] SnapMie     = 4'd2;
  localparam logic [3:0] SnapMedeleg = 4'd3;
  localparam logic [3:0] SnapMideleg = 4'd4;
  localparam logic [3:0] SnapMtvec   = 4'd5;
  localparam logic [3:0] SnapStvec   = 4'd6;
  localparam logic [3:0] SnapMepc    = 4'd7;
  localparam logic [3:0] SnapSepc    = 4'd8;

  // Write-back slots.
  localparam int unsigned NumWr = 5;
  localparam logic [2:0] WrMipOrCsr = 3'd0;
  localparam logic [2:0] WrEpc      = 3'd1;
  localparam logic [2:0] WrCause    = 3'd2;
  localparam logic [2:0] WrTval     = 3'd3;
  localparam logic [2:0] WrMstatus  = 3'd4;

  // Everything an item does, decided in one step from the snapshot.
  typedef struct packed {
    logic [NumWr-1:0]        wr_en;
    logic [NumWr-1:0][11:0]  wr_addr;
    logic [NumWr-1:0][63:0]  wr_data;
    logic [63:0]             read_data;
    logic                    redirect;
    logic [63:0]             next_pc;
    logic                    trap_taken;
    logic [1:0]              priv;
  } plan_t;

  // Store address of a snapshot slot.
  function automatic logic [11:0] snap_addr(input logic [3:0] slot);
    logic [11:0] a;
    a = AddrMstatus;
    case (slot)
      SnapMip:     a = AddrMip;
      SnapMie:     a = AddrMie;
      SnapMedeleg: a = AddrMedeleg;
      SnapMideleg: a = AddrMideleg;
      SnapMtvec:   a = AddrMtvec;
      SnapStvec:   a = AddrStvec;
      SnapMepc:    a = AddrMepc;
      SnapSepc:    a = AddrSepc;
      default:     a = AddrMstatus;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/core/mtcu_ram.sv]
// Single-port 4096 x 64 CSR store with registered read data.
// Depends on nothing.
`default_nettype none
module mtcu_ram (
  input  var logic        clk_i,
  input  var logic [11:0] addr_i,
  input  var logic        we_i,
  input  var logic [63:0] wdata_i,
  output var logic [63:0] rdata_o
);

  logic [63:0] mem [4096];
  logic [63:0] rdata_q;

  // One access per cycle: write or read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/mtcu_calc.sv]
// Decides CSR updates, trap entry and returns for one item from a snapshot.
// Depends on mtcu_pkg.
`default_nettype none
module mtcu_calc (
  input  var logic [3:0]                       action_i,
  input  var logic [11:0]                      csr_address_i,
  input  var logic [63:0]                      operand_value_i,
  input  var logic [63:0]                      instr_pc_i,
  input  var logic [5:0]                       exception_code_i,
  input  var logic [63:0]                      trap_value_i,
  input  var logic                             software_irq_i,
  input  var logic                             timer_irq_i,
  input  var logic [1:0]                       priv_i,
  input  var logic [mtcu_pkg::NumSnap-1:0][63:0] snap_i,
  output var mtcu_pkg::plan_t                  plan_o
);

  logic [63:0] ms, mip, pend, cause, tval, deleg, tvec, csr_new;
  logic [4:0]  code;
  logic        irq, do_trap, to_s, csr_ro;

  always_comb begin
    plan_o   = '0;
    plan_o.priv = priv_i;
    ms       = snap_i[mtcu_pkg::SnapMstatus];
    mip      = snap_i[mtcu_pkg::SnapMip];
    mip[3]   = software_irq_i;
    mip[7]   = timer_irq_i;
    pend     = mip & snap_i[mtcu_pkg::SnapMie];
    irq      = 1'b0;
    do_trap  = 1'b0;
    code     = 5'd0;
    tval     = 64'd0;
    csr_new  = operand_value_i;
    csr_ro   = (csr_address_i == mtcu_pkg::AddrMisa) ||
               (csr_address_i == mtcu_pkg::AddrMvendorid) ||
               (csr_address_i == mtcu_pkg::AddrMarchid) ||
               (csr_address_i == mtcu_pkg::AddrMimpid) ||
               (csr_address_i == mtcu_pkg::AddrMhartid);

    // Action decode.
    unique case (action_i) inside
      mtcu_pkg::ActCsrWrite, mtcu_pkg::ActCsrSet, mtcu_pkg::ActCsrClear: begin
        plan_o.read_data = snap_i[0];
        if (action_i == mtcu_pkg::ActCsrSet) begin
          csr_new = snap_i[0] | operand_value_i;
        end else if (action_i == mtcu_pkg::ActCsrClear) begin
          csr_new = snap_i[0] & ~operand_value_i;
        end
        if (csr_address_i == mtcu_pkg::AddrMstatus) begin
          csr_new = csr_new & mtcu_pkg::MstatusMask;
        end
        plan_o.wr_en[mtcu_pkg::WrMipOrCsr] = !csr_ro &&
          ((action_i == mtcu_pkg::ActCsrWrite) || (operand_value_i != 64'd0));
        plan_o.wr_addr[mtcu_pkg::WrMipOrCsr] = csr_address_i;
        plan_o.wr_data[mtcu_pkg::WrMipOrCsr] = csr_new;
      end
      mtcu_pkg::ActEcall: begin
        do_trap = 1'b1;
        code = (priv_i == mtcu_pkg::PrivMachine) ? 5'd11 :
               (priv_i == mtcu_pkg::PrivSuper) ? 5'd9 : 5'd8;
      end
      mtcu_pkg::ActEbreak: begin
        do_trap = 1'b1;
        code    = 5'd3;
        tval    = instr_pc_i;
      end
      mtcu_pkg::ActMret: begin
        plan_o.priv = ms[12:11];
        ms[3] = ms[7];
        ms[7] = 1'b1;
        ms[12:11] = 2'd0;
        plan_o.wr_en[mtcu_pkg::WrMstatus]   = 1'b1;
        plan_o.wr_addr[mtcu_pkg::WrMstatus] = mtcu_pkg::AddrMstatus;
        plan_o.wr_data[mtcu_pkg::WrMstatus] = ms & mtcu_pkg::MstatusMask;
        plan_o.redirect = 1'b1;
        plan_o.next_pc  = snap_i[mtcu_pkg::SnapMepc];
      end
      mtcu_pkg::ActSret: begin
        plan_o.priv = {1'b0, ms[8]};
        ms[1] = ms[5];
        ms[5] = 1'b1;
        ms[8] = 1'b0;
        plan_o.wr_en[mtcu_pkg::WrMstatus]   = 1'b1;
        plan_o.wr_addr[mtcu_pkg::WrMstatus] = mtcu_pkg::AddrMstatus;
        plan_o.wr_data[mtcu_pkg::WrMstatus] = ms & mtcu_pkg::MstatusMask;
        plan_o.redirect = 1'b1;
        plan_o.next_pc  = snap_i[mtcu_pkg::SnapSepc];
      end
      mtcu_pkg::ActExcept: begin
        do_trap = 1'b1;
        tval    = trap_value_i;
      end
      mtcu_pkg::ActIrqCheck: begin
        plan_o.wr_en[mtcu_pkg::WrMipOrCsr]   = 1'b1;
        plan_o.wr_addr[mtcu_pkg::WrMipOrCsr] = mtcu_pkg::AddrMip;
        plan_o.wr_data[mtcu_pkg::WrMipOrCsr] = mip;
        if ((priv_i != mtcu_pkg::PrivMachine) || ms[3]) begin
          // Fixed priority: MEI, MSI, MTI, SEI, SSI, STI.
          if (pend[11]) begin
            do_trap = 1'b1; code = 5'd11;
          end else if (pend[3]) begin
            do_trap = 1'b1; code = 5'd3;
          end else if (pend[7]) begin
            do_trap = 1'b1; code = 5'd7;
          end else if (pend[9]) begin
            do_trap = 1'b1; code = 5'd9;
          end else if (pend[1]) begin
            do_trap = 1'b1; code = 5'd1;
          end else if (pend[5]) begin
            do_trap = 1'b1; code = 5'd5;
          end
          irq = do_trap;
        end
      end
      default: begin
      end
    endcase

    // Trap entry with delegation and vectoring.
    if (irq) begin
      cause = {1'b1, 58'd0, code};
    end else if (action_i == mtcu_pkg::ActExcept) begin
      cause = {58'd0, exception_code_i};
    end else begin
      cause = {59'd0, code};
    end
    deleg = irq ? snap_i[mtcu_pkg::SnapMideleg] : snap_i[mtcu_pkg::SnapMedeleg];
    to_s  = ((priv_i == mtcu_pkg::PrivUser) || (priv_i == mtcu_pkg::PrivSuper)) &&
            deleg[cause[5:0]];
    if (to_s) begin
      ms[5] = ms[1];
      ms[1] = 1'b0;
      ms[8] = priv_i[0];
      tvec  = snap_i[mtcu_pkg::SnapStvec];
    end else begin
      ms[7] = ms[3];
      ms[3] = 1'b0;
      ms[12:11] = priv_i;
      tvec  = snap_i[mtcu_pkg::SnapMtvec];
    end
    if (do_trap) begin
      plan_o.wr_en[mtcu_pkg::WrEpc]     = 1'b1;
      plan_o.wr_en[mtcu_pkg::WrCause]   = 1'b1;
      plan_o.wr_en[mtcu_pkg::WrTval]    = 1'b1;
      plan_o.wr_en[mtcu_pkg::WrMstatus] = 1'b1;
      plan_o.wr_addr[mtcu_pkg::WrEpc]   = to_s ? mtcu_pkg::AddrSepc : mtcu_pkg::AddrMepc;
      plan_o.wr_addr[mtcu_pkg::WrCause] = to_s ? mtcu_pkg::AddrScause : mtcu_pkg::AddrMcause;
      plan_o.wr_addr[mtcu_pkg::WrTval]  = to_s ? mtcu_pkg::AddrStval : mtcu_pkg::AddrMtval;
      plan_o.wr_addr[mtcu_pkg::WrMstatus] = mtcu_pkg::AddrMstatus;
      plan_o.wr_data[mtcu_pkg::WrEpc]     = instr_pc_i;
      plan_o.wr_data[mtcu_pkg::WrCause]   = cause;
      plan_o.wr_data[mtcu_pkg::WrTval]    = tval;
      plan_o.wr_data[mtcu_pkg::WrMstatus] = ms & mtcu_pkg::MstatusMask;
      plan_o.priv       = to_s ? mtcu_pkg::PrivSuper : mtcu_pkg::PrivMachine;
      plan_o.redirect   = 1'b1;
      plan_o.trap_taken = 1'b1;
      plan_o.next_pc    = {tvec[63:2], 2'b00} +
                          (((tvec[1:0] == 2'd1) && irq) ? {57'd0, code, 2'b00} : 64'd0);
    end
  end

endmodule
`default_nettype wire

[rtl/core/machine_trap_and_csr_unit.sv]
// Top level of the machine trap and CSR unit: sequencer around the CSR store.
// Depends on mtcu_pkg, mtcu_ram and mtcu_calc.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries an item with an
// action and its operands; one output channel (out_valid_o / out_stall_i)
// returns exactly one result item per input item, in order.
// The CSR store is a single-port 4096 x 64 memory, one access per cycle.
// After reset the unit sweeps all 4096 entries of the store, clearing them and
// loading misa; in_stall_o stays high during that sweep. Privilege resets
// to machine mode.
// Steps per item: a CSR operation reads one entry, a system action reads
// nine entries; then the last read drains, the plan is decided in StCalc and
// the write-back slots are written in turn. An item is not accepted until the
// previous result has been loaded into the output register.
// The result sits in an output register; the next item may be accepted while
// it waits, and a stalled receiver holds the unit only when a second result
// is ready to be loaded.
`default_nettype none
module machine_trap_and_csr_unit (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output var logic        in_stall_o,
  input  var logic [3:0]  action_i,
  input  var logic [11:0] csr_address_i,
  input  var logic [63:0] operand_value_i,
  input  var logic [63:0] instr_pc_i,
  input  var logic [5:0]  exception_code_i,
  input  var logic [63:0] trap_value_i,
  input  var logic        software_irq_i,
  input  var logic        timer_irq_i,
  output var logic        out_valid_o,
  input  var logic        out_stall_i,
  output var logic [63:0] read_data_o,
  output var logic        redirect_o,
  output var logic [63:0] next_pc_o,
  output var logic        trap_taken_o,
  output var logic [1:0]  privilege_level_o
);

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StRead  = 7'b0000100,
    StDrain = 7'b0001000,
    StCalc  = 7'b0010000,
    StWrite = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [11:0] clr_cnt_q;
  logic [3:0]  rd_cnt_q;
  logic [3:0]  cap_idx_q;
  logic        cap_vld_q;
  logic [2:0]  wr_cnt_q;
  logic [1:0]  priv_q;

  // Latched item.
  logic [3:0]  action_q;
  logic [11:0] csr_address_q;
  logic [63:0] operand_value_q, instr_pc_q, trap_value_q;
  logic [5:0]  exception_code_q;
  logic        software_irq_q, timer_irq_q;

  logic [mtcu_pkg::NumSnap-1:0][63:0] snap_q;
  mtcu_pkg::plan_t plan_d, plan_q;

  logic [11:0] ram_addr;
  logic        ram_we;
  logic [63:0] ram_wdata, ram_rdata;
  logic        is_csr_op, rd_last, accept, out_load;

  logic        out_valid_q;
  logic [63:0] out_read_data_q, out_next_pc_q;
  logic        out_redirect_q, out_trap_q;
  logic [1:0]  out_priv_q;

  assign is_csr_op = (action_q == mtcu_pkg::ActCsrWrite) ||
                     (action_q == mtcu_pkg::ActCsrSet) ||
                     (action_q == mtcu_pkg::ActCsrClear);
  assign rd_last   = is_csr_op || (rd_cnt_q == 4'(mtcu_pkg::NumSnap - 1));
  assign accept    = in_valid_i && !in_stall_o;
  assign out_load  = (state_q == StDone) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != StIdle);

  // Store port selection.
  always_comb begin
    ram_addr  = mtcu_pkg::snap_addr(rd_cnt_q);
    ram_we    = 1'b0;
    ram_wdata = 64'd0;
    unique case (state_q)
      StClear: begin
        ram_addr  = clr_cnt_q;
        ram_we    = 1'b1;
        ram_wdata = (clr_cnt_q == mtcu_pkg::AddrMisa) ? mtcu_pkg::MisaValue : 64'd0;
      end
      StRead: begin
        ram_addr = is_csr_op ? csr_address_q : mtcu_pkg::snap_addr(rd_cnt_q);
      end
      StWrite: begin
        ram_addr  = plan_q.wr_addr[wr_cnt_q];
        ram_we    = plan_q.wr_en[wr_cnt_q];
        ram_wdata = plan_q.wr_data[wr_cnt_q];
      end
      default: begin
      end
    endcase
  end

  mtcu_ram u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  mtcu_calc u_calc (
    .action_i         (action_q),
    .csr_address_i    (csr_address_q),
    .operand_value_i  (operand_value_q),
    .instr_pc_i       (instr_pc_q),
    .exception_code_i (exception_code_q),
    .trap_value_i     (trap_value_q),
    .software_irq_i   (software_irq_q),
    .timer_irq_i      (timer_irq_q),
    .priv_i           (priv_q),
    .snap_i           (snap_q),
    .plan_o           (plan_d)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_cnt_q == 12'hFFF) state_d = StIdle;
      StIdle:  if (accept) state_d = StRead;
      StRead:  if (rd_last) state_d = StDrain;
      StDrain: state_d = StCalc;
      StCalc:  state_d = StWrite;
      StWrite: if (wr_cnt_q == 3'(mtcu_pkg::NumWr - 1)) state_d = StDone;
      StDone:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= 12'd0;
      rd_cnt_q    <= 4'd0;
      cap_idx_q   <= 4'd0;
      cap_vld_q   <= 1'b0;
      wr_cnt_q    <= 3'd0;
      priv_q      <= mtcu_pkg::PrivMachine;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_vld_q <= (state_q == StRead);
      cap_idx_q <= rd_cnt_q;
      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + 12'd1;
      end
      if (state_q == StRead) begin
        rd_cnt_q <= rd_last ? 4'd0 : rd_cnt_q + 4'd1;
      end
      if (state_q == StWrite) begin
        wr_cnt_q <= (wr_cnt_q == 3'(mtcu_pkg::NumWr - 1)) ? 3'd0 : wr_cnt_q + 3'd1;
      end
      if (out_load) begin
        priv_q      <= plan_q.priv;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: item latch, snapshot capture, plan and result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q         <= action_i;
      csr_address_q    <= csr_address_i;
      operand_value_q  <= operand_value_i;
      instr_pc_q       <= instr_pc_i;
      exception_code_q <= exception_code_i;
      trap_value_q     <= trap_value_i;
      software_irq_q   <= software_irq_i;
      timer_irq_q      <= timer_irq_i;
    end
    if (cap_vld_q) begin
      snap_q[cap_idx_q] <= ram_rdata;
    end
    if (state_q == StCalc) begin
      plan_q <= plan_d;
    end
    if (out_load) begin
      out_read_data_q <= plan_q.read_data;
      out_redirect_q  <= plan_q.redirect;
      out_next_pc_q   <= plan_q.next_pc;
      out_trap_q      <= plan_q.trap_taken;
      out_priv_q      <= plan_q.priv;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_read_data_q;
  assign redirect_o        = out_redirect_q;
  assign next_pc_o         = out_next_pc_q;
  assign trap_taken_o      = out_trap_q;
  assign privilege_level_o = out_priv_q;

endmodule
`default_nettype wire

[rtl/core/mtcu_checker.sv]
// Port-level checks of the machine trap and CSR unit, bound to the top level.
// Depends on machine_trap_and_csr_unit.
`default_nettype none
module mtcu_checker (
  input var logic        clk_i,
  input var logic        rst_ni,
  input var logic        out_valid_o,
  input var logic        out_stall_i,
  input var logic        redirect_o,
  input var logic [63:0] next_pc_o,
  input var logic        trap_taken_o,
  input var logic [1:0]  privilege_level_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A trap always redirects.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trap_taken_o |-> redirect_o)
    else $error("trap without redirect");

  // No redirect means no target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !redirect_o |-> next_pc_o == 64'd0)
    else $error("target without redirect");

  // A trap lands in supervisor or machine mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trap_taken_o |-> privilege_level_o == 2'd1 || privilege_level_o == 2'd3)
    else $error("trap landed in a wrong mode");

endmodule

bind machine_trap_and_csr_unit mtcu_checker u_mtcu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .redirect_o        (redirect_o),
  .next_pc_o         (next_pc_o),
  .trap_taken_o      (trap_taken_o),
  .privilege_level_o (privilege_level_o)
);
`default_nettype wire

[verif/machine_trap_and_csr_unit_test.sv]
// Self-checking testbench of the machine trap and CSR unit.
// Depends on mtcu_pkg and the RTL of machine_trap_and_csr_unit.
`default_nettype none
module machine_trap_and_csr_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package does not name.
  localparam logic [3:0]  ActUnusedLo  = 4'd9;
  localparam logic [3:0]  ActUnusedHi  = 4'd15;
  localparam logic [63:0] CauseBreak   = 64'd3;
  localparam logic [63:0] CauseEcallU  = 64'd8;
  localparam logic [63:0] CauseEcallS  = 64'd9;
  localparam logic [63:0] CauseEcallM  = 64'd11;
  localparam logic [63:0] IrqFlag      = 64'd1 << 63;
  localparam int unsigned BitSie = 1, BitMie = 3, BitSpie = 5, BitMpie = 7, BitSpp = 8;
  localparam int unsigned BitMsip = 3, BitMtip = 7;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [3:0]  action;
    logic [11:0] addr;
    logic [63:0] operand;
    logic [63:0] pc;
    logic [5:0]  ecode;
    logic [63:0] tval;
    logic        swi;
    logic        tmi;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        redirect;
    logic [63:0] next_pc;
    logic        trap_taken;
    logic [1:0]  priv;
  } result_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b1;
  logic in_stall_o, out_valid_o;
  logic [3:0]  action_i = '0;
  logic [11:0] csr_address_i = '0;
  logic [63:0] operand_value_i = '0, instr_pc_i = '0, trap_value_i = '0;
  logic [5:0]  exception_code_i = '0;
  logic        software_irq_i = 1'b0, timer_irq_i = 1'b0;
  logic [63:0] read_data_o, next_pc_o;
  logic        redirect_o, trap_taken_o;
  logic [1:0]  privilege_level_o;

  // Mirror of the unit's state and the results still owed.
  logic [63:0] csr_mirror [4096];
  logic [1:0]  priv_mirror;
  result_t     owed_results[$];
  int unsigned err_count = 0, idle_cycles = 0, items_sent = 0, results_seen = 0;
  int unsigned traps_seen = 0;
  bit          burst_mode = 1'b0;
  logic [3:0]  irq_order [6] = '{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5};

  machine_trap_and_csr_unit u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void mirror_write(input logic [11:0] a, input logic [63:0] v);
    if (a == mtcu_pkg::AddrMhartid || a == mtcu_pkg::AddrMvendorid ||
        a == mtcu_pkg::AddrMarchid || a == mtcu_pkg::AddrMimpid ||
        a == mtcu_pkg::AddrMisa) return;
    csr_mirror[a] = (a == mtcu_pkg::AddrMstatus) ? (v & mtcu_pkg::MstatusMask) : v;
  endfunction

  // Trap entry with delegation; returns the vector target.
  function automatic logic [63:0] take_trap(input logic [63:0] cause, input logic [63:0] tv,
                                            input logic [63:0] epc);
    logic        is_irq;
    logic [30:0] code;
    logic [63:0] deleg, ms, tvec;
    logic        to_s;
    is_irq = cause[63];
    code = cause[30:0];
    deleg = is_irq ? csr_mirror[mtcu_pkg::AddrMideleg] : csr_mirror[mtcu_pkg::AddrMedeleg];
    to_s = (priv_mirror <= mtcu_pkg::PrivSuper) && (code < 64) && deleg[code[5:0]];
    ms = csr_mirror[mtcu_pkg::AddrMstatus];
    if (to_s) begin
      mirror_write(mtcu_pkg::AddrSepc, epc);
      mirror_write(mtcu_pkg::AddrScause, cause);
      mirror_write(mtcu_pkg::AddrStval, tv);
      ms[BitSpie] = ms[BitSie];
      ms[BitSie] = 1'b0;
      ms[BitSpp] = priv_mirror[0];
      mirror_write(mtcu_pkg::AddrMstatus, ms);
      priv_mirror = mtcu_pkg::PrivSuper;
      tvec = csr_mirror[mtcu_pkg::AddrStvec];
    end else begin
      mirror_write(mtcu_pkg::AddrMepc, epc);
      mirror_write(mtcu_pkg::AddrMcause, cause);
      mirror_write(mtcu_pkg::AddrMtval, tv);
      ms[BitMpie] = ms[BitMie];
      ms[BitMie] = 1'b0;
      ms[12:11] = priv_mirror;
      mirror_write(mtcu_pkg::AddrMstatus, ms);
      priv_mirror = mtcu_pkg::PrivMachine;
      tvec = csr_mirror[mtcu_pkg::AddrMtvec];
    end
    if (tvec[1:0] == 2'd1 && is_irq) return {tvec[63:2], 2'b00} + 64'd4 * code;
    return {tvec[63:2], 2'b00};
  endfunction

  function automatic result_t predict_result(input item_t it);
    result_t r;
    logic [63:0] ms, mip, pend;
    logic [1:0]  back;
    r = '0;
    case (it.action)
      mtcu_pkg::ActCsrWrite: begin
        r.read_data = csr_mirror[it.addr];
        mirror_write(it.addr, it.operand);
      end
      mtcu_pkg::ActCsrSet: begin
        r.read_data = csr_mirror[it.addr];
        if (it.operand != 0) mirror_write(it.addr, r.read_data | it.operand);
      end
      mtcu_pkg::ActCsrClear: begin
        r.read_data = csr_mirror[it.addr];
        if (it.operand != 0) mirror_write(it.addr, r.read_data & ~it.operand);
      end
      mtcu_pkg::ActEcall: begin
        r.next_pc = take_trap(priv_mirror == mtcu_pkg::PrivMachine ? CauseEcallM :
                              priv_mirror == mtcu_pkg::PrivSuper ? CauseEcallS : CauseEcallU,
                              64'd0, it.pc);
        r.redirect = 1'b1;
        r.trap_taken = 1'b1;
      end
      mtcu_pkg::ActEbreak: begin
        r.next_pc = take_trap(CauseBreak, it.pc, it.pc);
        r.redirect = 1'b1;
        r.trap_taken = 1'b1;
      end
      mtcu_pkg::ActMret: begin
        ms = csr_mirror[mtcu_pkg::AddrMstatus];
        back = ms[12:11];
        ms[BitMie] = ms[BitMpie];
        ms[BitMpie] = 1'b1;
        ms[12:11] = mtcu_pkg::PrivUser;
        mirror_write(mtcu_pkg::AddrMstatus, ms);
        priv_mirror = back;
        r.next_pc = csr_mirror[mtcu_pkg::AddrMepc];
        r.redirect = 1'b1;
      end
      mtcu_pkg::ActSret: begin
        ms = csr_mirror[mtcu_pkg::AddrMstatus];
        back = {1'b0, ms[BitSpp]};
        ms[BitSie] = ms[BitSpie];
        ms[BitSpie] = 1'b1;
        ms[BitSpp] = 1'b0;
        mirror_write(mtcu_pkg::AddrMstatus, ms);
        priv_mirror = back;
        r.next_pc = csr_mirror[mtcu_pkg::AddrSepc];
        r.redirect = 1'b1;
      end
      mtcu_pkg::ActExcept: begin
        r.next_pc = take_trap({58'd0, it.ecode}, it.tval, it.pc);
        r.redirect = 1'b1;
        r.trap_taken = 1'b1;
      end
      mtcu_pkg::ActIrqCheck: begin
        ms = csr_mirror[mtcu_pkg::AddrMstatus];
        mip = csr_mirror[mtcu_pkg::AddrMip];
        mip[BitMsip] = it.swi;
        mip[BitMtip] = it.tmi;
        csr_mirror[mtcu_pkg::AddrMip] = mip;
        if (priv_mirror != mtcu_pkg::PrivMachine || ms[BitMie]) begin
          pend = mip & csr_mirror[mtcu_pkg::AddrMie];
          for (int i = 0; i < 6; i++) begin
            if (!r.trap_taken && pend[irq_order[i]]) begin
              r.next_pc = take_trap(IrqFlag | irq_order[i], 64'd0, it.pc);
              r.redirect = 1'b1;
              r.trap_taken = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.priv = priv_mirror;
    return r;
  endfunction

  // Drives one item at falling edges, waits for acceptance, records the prediction.
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = it.action;
    csr_address_i = it.addr;
    operand_value_i = it.operand;
    instr_pc_i = it.pc;
    exception_code_i = it.ecode;
    trap_value_i = it.tval;
    software_irq_i = it.swi;
    timer_irq_i = it.tmi;
    forever begin
      #0.9;
      if (!in_stall_o) break;
      @(negedge clk_i);
    end
    @(posedge clk_i);
    owed_results.push_back(predict_result(it));
    items_sent++;
  endtask

  // Result side: random stall, then compare each accepted result in order.
  initial begin
    result_t exp_r;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 19);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      forever begin
        #0.9;
        if (out_valid_o) break;
        @(negedge clk_i);
      end
      @(posedge clk_i);
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result with no item outstanding");
        err_count++;
      end else begin
        exp_r = owed_results.pop_front();
        if (exp_r.trap_taken) traps_seen++;
        if (read_data_o !== exp_r.read_data) begin
          $error("read_data expected %h got %h", exp_r.read_data, read_data_o);
          err_count++;
        end
        if (redirect_o !== exp_r.redirect) begin
          $error("redirect expected %h got %h", exp_r.redirect, redirect_o);
          err_count++;
        end
        if (next_pc_o !== exp_r.next_pc) begin
          $error("next_pc expected %h got %h", exp_r.next_pc, next_pc_o);
          err_count++;
        end
        if (trap_taken_o !== exp_r.trap_taken) begin
          $error("trap_taken expected %h got %h", exp_r.trap_taken, trap_taken_o);
          err_count++;
        end
        if (privilege_level_o !== exp_r.priv) begin
          $error("privilege_level expected %h got %h", exp_r.priv, privilege_level_o);
          err_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t make_item(input logic [3:0] act, input logic [11:0] a,
                                      input logic [63:0] v);
    item_t it;
    it.action = act;
    it.addr = a;
    it.operand = v;
    it.pc = rand64();
    it.ecode = $urandom_range(0, 63);
    it.tval = rand64();
    it.swi = $urandom_range(0, 1);
    it.tmi = $urandom_range(0, 1);
    return it;
  endfunction

  // A CSR address, mostly one of those that the package names.
  function automatic logic [11:0] pick_addr();
    logic [11:0] known [18] = '{mtcu_pkg::AddrMstatus, mtcu_pkg::AddrMisa,
      mtcu_pkg::AddrMedeleg, mtcu_pkg::AddrMideleg, mtcu_pkg::AddrMie,
      mtcu_pkg::AddrMtvec, mtcu_pkg::AddrMepc, mtcu_pkg::AddrMcause,
      mtcu_pkg::AddrMtval, mtcu_pkg::AddrMip, mtcu_pkg::AddrStvec, mtcu_pkg::AddrSepc,
      mtcu_pkg::AddrScause, mtcu_pkg::AddrStval, mtcu_pkg::AddrMvendorid,
      mtcu_pkg::AddrMarchid, mtcu_pkg::AddrMimpid, mtcu_pkg::AddrMhartid};
    if ($urandom_range(0, 9) < 8) return known[$urandom_range(0, 17)];
    return $urandom_range(0, 4095);
  endfunction

  // A CSR operand: random, zero, all ones, or a few bits.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return {$urandom_range(0, 3)} | ({$urandom_range(0, 3)} << 11) | (64'd1 << BitMie);
      default: return rand64();
    endcase
  endfunction

  task automatic test_directed();
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMstatus, '1));
    send_item(make_item(mtcu_pkg::ActCsrSet, mtcu_pkg::AddrMstatus, '0));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMisa, '0));
    send_item(make_item(mtcu_pkg::ActCsrClear, mtcu_pkg::AddrMisa, '1));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMhartid, '1));
    send_item(make_item(mtcu_pkg::ActCsrWrite, 12'hFFF, '1));
    send_item(make_item(mtcu_pkg::ActCsrClear, 12'hFFF, '0));
    send_item(make_item(mtcu_pkg::ActCsrClear, 12'h000, '1));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMtvec,
                        64'h8000_0000_0000_0101));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrStvec,
                        64'h0000_0000_0000_4001));
    send_item(make_item(mtcu_pkg::ActEcall, '0, '0));
    send_item(make_item(mtcu_pkg::ActEbreak, '0, '0));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMedeleg, '1));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMideleg, '1));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMstatus, 64'd2 << 11));
    send_item(make_item(mtcu_pkg::ActMret, '0, '0));
    send_item(make_item(mtcu_pkg::ActEcall, '0, '0));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMstatus,
                        (64'd0 << 11) | (64'd1 << BitMpie)));
    send_item(make_item(mtcu_pkg::ActMret, '0, '0));
    send_item(make_item(mtcu_pkg::ActEcall, '0, '0));
    send_item(make_item(mtcu_pkg::ActSret, '0, '0));
    send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMie, '1));
    send_item(make_item(mtcu_pkg::ActIrqCheck, '0, '0));
    send_item(make_item(mtcu_pkg::ActExcept, '0, '0));
    send_item(make_item(ActUnusedHi, 12'hFFF, '1));
  endtask

  // Random mix of CSR operations, armed interrupt checks, system actions and unused codes.
  task automatic test_random_mix(input int unsigned count);
    int unsigned kind;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_item(make_item($urandom_range(mtcu_pkg::ActCsrWrite, mtcu_pkg::ActCsrClear),
                            pick_addr(), pick_operand()));
      end else if (kind < 55) begin
        // Arm interrupts, then check the pending lines.
        send_item(make_item(mtcu_pkg::ActCsrWrite, mtcu_pkg::AddrMie, rand64()));
        send_item(make_item(mtcu_pkg::ActCsrSet, mtcu_pkg::AddrMstatus, 64'd1 << BitMie));
        send_item(make_item(mtcu_pkg::ActIrqCheck, pick_addr(), rand64()));
        n += 2;
      end else if (kind < 92) begin
        send_item(make_item($urandom_range(mtcu_pkg::ActEcall, mtcu_pkg::ActIrqCheck),
                            pick_addr(), rand64()));
      end else begin
        send_item(make_item($urandom_range(ActUnusedLo, ActUnusedHi), pick_addr(),
                            rand64()));
      end
    end
    burst_mode = 1'b0;
  endtask

  // The sender holds off until every owed result has come back.
  task automatic test_drain_pause();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (owed_results.size() == 0);
    send_item(make_item(mtcu_pkg::ActIrqCheck, '0, '0));
    send_item(make_item(mtcu_pkg::ActMret, '0, '0));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < 4096; i++) csr_mirror[i] = '0;
    csr_mirror[mtcu_pkg::AddrMisa] = mtcu_pkg::MisaValue;
    priv_mirror = mtcu_pkg::PrivMachine;
    test_directed();
    test_random_mix(500);
    test_drain_pause();
    test_random_mix(600);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (owed_results.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items over all actions; %0d results checked, %0d of them traps.",
             items_sent, results_seen, traps_seen);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
